// ===== rtl/core/rcfu_pkg.sv =====
// Shared types, constants and register codes for the receiver frame unpacker.
`timescale 1ns / 1ps

package rcfu_pkg;

  localparam int FRAME_BYTES_DEF = 18;
  localparam int BYTE_W          = 8;
  localparam int VAL_W           = 11;
  localparam int SW_W            = 2;
  localparam int CNT_W           = 10;
  localparam int NUM_STICKS      = 4;
  localparam int HEAD_BYTES      = 6;
  localparam int HEAD_W          = HEAD_BYTES * BYTE_W;
  localparam int WHEEL_HI_W      = VAL_W - BYTE_W;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = VAL_W;

  // byte positions of the wheel channel inside a frame
  localparam int WHEEL_LO_POS = 16;
  localparam int WHEEL_HI_POS = 17;

  // result word: sticks, switches, wheel, counter, padded to whole bytes
  localparam int OUT_RAW_W  = NUM_STICKS * VAL_W + 2 * SW_W + VAL_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] STICK_MIN_RST    = 11'd364;
  localparam logic [VAL_W-1:0] STICK_MAX_RST    = 11'd1684;
  localparam logic [VAL_W-1:0] DEAD_LOW_RST     = 11'd1020;
  localparam logic [VAL_W-1:0] DEAD_HIGH_RST    = 11'd1028;
  localparam logic [VAL_W-1:0] STICK_CENTER_RST = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_LIMIT_RST  = 10'd1000;
  localparam logic [VAL_W-1:0] HELD_VAL_RST     = 11'd1024;
  localparam logic [SW_W-1:0]  HELD_SW_RST      = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_MIN    = 3'd0,
    CFG_STICK_MAX    = 3'd1,
    CFG_DEAD_LOW     = 3'd2,
    CFG_DEAD_HIGH    = 3'd3,
    CFG_STICK_CENTER = 3'd4,
    CFG_COUNT_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0] stick_min;
    logic [VAL_W-1:0] stick_max;
    logic [VAL_W-1:0] dead_low;
    logic [VAL_W-1:0] dead_high;
    logic [VAL_W-1:0] stick_center;
    logic [CNT_W-1:0] count_limit;
  } cfg_t;

  // raw frame fields captured from the byte stream
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [VAL_W-1:0]  wheel;
  } frame_t;

  typedef struct packed {
    logic [NUM_STICKS-1:0][VAL_W-1:0] sticks;
    logic [SW_W-1:0]                  sw_left;
    logic [SW_W-1:0]                  sw_right;
    logic [VAL_W-1:0]                 wheel;
  } held_t;

  typedef struct packed {
    logic  ok;
    held_t vals;
  } eval_t;

endpackage

// ===== rtl/core/rc_frame_unpacker.sv =====
// Top level of the remote-control receiver frame unpacker.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: rx_byte; tuser: frame_start
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: sticks, switches, wheel, count;
//                                             tuser: frame_ok
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle unless stalled; the last byte sets fin, then the result loads.
// The byte input stalls only while a finished frame waits and the result register is
// still held by a stalled output; the capture-to-result register pair sets this.
// Reset loads the default registers, centers held sticks and wheel, sets both switches
// to 3, clears the frame counter and aligns the byte position to a frame start.
`timescale 1ns / 1ps

module rc_frame_unpacker #(
  parameter int FRAME_BYTES = rcfu_pkg::FRAME_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rcfu_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
  input  logic                              s_axis_tuser,   // [0] frame_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [10:0] stick_0, [21:11] stick_1, [32:22] stick_2, [43:33] stick_3,
  // [45:44] switch_left, [47:46] switch_right, [58:48] wheel, [68:59] frame_total
  output logic [rcfu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,   // [0] frame_ok
  input  logic                              cfg_we_i,
  input  logic [rcfu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcfu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  rcfu_pkg::cfg_t   cfg;
  rcfu_pkg::frame_t frame;
  rcfu_pkg::eval_t  eval;
  logic             fin;
  logic             take;
  logic             in_xfer;

  assign s_axis_tready = !fin || take;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  rcfu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  rcfu_capture #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .byte_i   (s_axis_tdata),
    .start_i  (s_axis_tuser),
    .done_i   (take),
    .fin_o    (fin),
    .frame_o  (frame)
  );

  rcfu_eval u_eval (
    .frame_i (frame),
    .cfg_i   (cfg),
    .eval_o  (eval)
  );

  rcfu_hold u_hold (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fin_i         (fin),
    .eval_i        (eval),
    .count_limit_i (cfg.count_limit),
    .take_o        (take),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_o     (m_axis_tdata),
    .m_tuser_o     (m_axis_tuser)
  );

endmodule

// ===== rtl/core/rcfu_cfg.sv =====
// Configuration register file for the receiver frame unpacker.
`timescale 1ns / 1ps

module rcfu_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [rcfu_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [rcfu_pkg::CFG_DATA_W-1:0] wdata_i,
  output rcfu_pkg::cfg_t                  cfg_o
);

  rcfu_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (rcfu_pkg::cfg_idx_e'(idx_i))
        rcfu_pkg::CFG_STICK_MIN:    cfg_d.stick_min    = wdata_i;
        rcfu_pkg::CFG_STICK_MAX:    cfg_d.stick_max    = wdata_i;
        rcfu_pkg::CFG_DEAD_LOW:     cfg_d.dead_low     = wdata_i;
        rcfu_pkg::CFG_DEAD_HIGH:    cfg_d.dead_high    = wdata_i;
        rcfu_pkg::CFG_STICK_CENTER: cfg_d.stick_center = wdata_i;
        rcfu_pkg::CFG_COUNT_LIMIT:  cfg_d.count_limit  = wdata_i[rcfu_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_min    <= rcfu_pkg::STICK_MIN_RST;
      cfg_q.stick_max    <= rcfu_pkg::STICK_MAX_RST;
      cfg_q.dead_low     <= rcfu_pkg::DEAD_LOW_RST;
      cfg_q.dead_high    <= rcfu_pkg::DEAD_HIGH_RST;
      cfg_q.stick_center <= rcfu_pkg::STICK_CENTER_RST;
      cfg_q.count_limit  <= rcfu_pkg::COUNT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/rcfu_capture.sv =====
// Byte position tracking and capture of the frame bytes that carry channel data.
`timescale 1ns / 1ps

module rcfu_capture #(
  parameter int FRAME_BYTES = rcfu_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [rcfu_pkg::BYTE_W-1:0]  byte_i,
  input  logic                         start_i,
  input  logic                         done_i,
  output logic                         fin_o,
  output rcfu_pkg::frame_t             frame_o
);

  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] END_POS   = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] HEAD_END  = POS_W'(rcfu_pkg::HEAD_BYTES);
  localparam logic [POS_W-1:0] WLO_POS   = POS_W'(rcfu_pkg::WHEEL_LO_POS);
  localparam logic [POS_W-1:0] WHI_POS   = POS_W'(rcfu_pkg::WHEEL_HI_POS);
  localparam int HIDX_W = $clog2(rcfu_pkg::HEAD_BYTES);

  logic [POS_W-1:0] pos_q, pos_d, cur_pos;
  logic             fin_q, fin_d;
  logic             take_byte;

  logic [rcfu_pkg::BYTE_W-1:0]     head_q [rcfu_pkg::HEAD_BYTES];
  logic [rcfu_pkg::BYTE_W-1:0]     wlo_q;
  logic [rcfu_pkg::WHEEL_HI_W-1:0] whi_q;

  // a start flag realigns the frame before the byte is placed
  assign cur_pos   = start_i ? '0 : pos_q;
  assign take_byte = accept_i && (cur_pos < END_POS);

  always_comb begin
    pos_d = pos_q;
    fin_d = fin_q && !done_i;
    if (take_byte) begin
      pos_d = cur_pos + POS_W'(1);
      if (cur_pos == LAST_POS) begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      fin_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_byte) begin
      if (cur_pos < HEAD_END) begin
        head_q[cur_pos[HIDX_W-1:0]] <= byte_i;
      end
      if (cur_pos == WLO_POS) begin
        wlo_q <= byte_i;
      end
      if (cur_pos == WHI_POS) begin
        whi_q <= byte_i[rcfu_pkg::WHEEL_HI_W-1:0];
      end
    end
  end

  assign fin_o = fin_q;
  assign frame_o.head  = {head_q[5], head_q[4], head_q[3], head_q[2], head_q[1], head_q[0]};
  assign frame_o.wheel = {whi_q, wlo_q};

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= END_POS)
    else $error("byte position ran past the frame end");

  a_fin_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> pos_q == END_POS)
    else $error("frame finish pending without a complete frame");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q && !done_i |=> fin_q && $stable(frame_o))
    else $error("pending frame lost or overwritten while stalled");

endmodule

// ===== rtl/core/rcfu_eval.sv =====
// Unpacks the stick and switch channels, checks the frame and applies the dead band.
`timescale 1ns / 1ps

module rcfu_eval (
  input  rcfu_pkg::frame_t frame_i,
  input  rcfu_pkg::cfg_t   cfg_i,
  output rcfu_pkg::eval_t  eval_o
);

  logic [rcfu_pkg::NUM_STICKS-1:0][rcfu_pkg::VAL_W-1:0] ch;
  logic [rcfu_pkg::NUM_STICKS-1:0]                      in_range;
  logic [rcfu_pkg::SW_W-1:0]                            sw_l, sw_r;

  // sticks are packed back to back as an LSB-first bit stream
  assign ch   = frame_i.head[rcfu_pkg::NUM_STICKS*rcfu_pkg::VAL_W-1:0];
  assign sw_l = frame_i.head[47:46];
  assign sw_r = frame_i.head[45:44];

  always_comb begin
    for (int i = 0; i < rcfu_pkg::NUM_STICKS; i++) begin
      in_range[i] = (ch[i] >= cfg_i.stick_min) && (ch[i] <= cfg_i.stick_max);
      if ((ch[i] > cfg_i.dead_low) && (ch[i] < cfg_i.dead_high)) begin
        eval_o.vals.sticks[i] = cfg_i.stick_center;
      end else begin
        eval_o.vals.sticks[i] = ch[i];
      end
    end
    eval_o.ok            = (sw_l != '0) && (sw_r != '0) && (&in_range);
    eval_o.vals.sw_left  = sw_l;
    eval_o.vals.sw_right = sw_r;
    eval_o.vals.wheel    = frame_i.wheel;
  end

endmodule

// ===== rtl/core/rcfu_hold.sv =====
// Held channel values, saturating frame counter and the result register.
`timescale 1ns / 1ps

module rcfu_hold (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fin_i,
  input  rcfu_pkg::eval_t                   eval_i,
  input  logic [rcfu_pkg::CNT_W-1:0]        count_limit_i,
  output logic                              take_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [rcfu_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  output logic                              m_tuser_o
);

  rcfu_pkg::held_t            held_q, held_d;
  logic [rcfu_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [rcfu_pkg::CNT_W:0]   cnt_inc;
  logic                       ovalid_q;
  rcfu_pkg::held_t            oval_q;
  logic [rcfu_pkg::CNT_W-1:0] ototal_q;
  logic                       ook_q;

  // result register is free when empty or drained this cycle
  assign take_o = fin_i && (!ovalid_q || m_tready_i);

  assign cnt_inc = {1'b0, cnt_q} + (rcfu_pkg::CNT_W+1)'(1);
  assign cnt_d   = (cnt_inc > {1'b0, count_limit_i}) ? count_limit_i
                                                      : cnt_inc[rcfu_pkg::CNT_W-1:0];
  assign held_d  = eval_i.ok ? eval_i.vals : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      for (int i = 0; i < rcfu_pkg::NUM_STICKS; i++) begin
        held_q.sticks[i] <= rcfu_pkg::HELD_VAL_RST;
      end
      held_q.sw_left  <= rcfu_pkg::HELD_SW_RST;
      held_q.sw_right <= rcfu_pkg::HELD_SW_RST;
      held_q.wheel    <= rcfu_pkg::HELD_VAL_RST;
    end else begin
      if (take_o) begin
        ovalid_q <= 1'b1;
        cnt_q    <= cnt_d;
        held_q   <= held_d;
      end else if (m_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      oval_q   <= held_d;
      ototal_q <= cnt_d;
      ook_q    <= eval_i.ok;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tuser_o  = ook_q;
  assign m_tdata_o  = {{(rcfu_pkg::OUT_DATA_W - rcfu_pkg::OUT_RAW_W){1'b0}},
                       ototal_q, oval_q.wheel, oval_q.sw_right, oval_q.sw_left,
                       oval_q.sticks};

  a_fail_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && !eval_i.ok |=> held_q == $past(held_q))
    else $error("held values changed on a rejected frame");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> (cnt_q == $past(cnt_q) + rcfu_pkg::CNT_W'(1)) || (cnt_q == $past(count_limit_i)))
    else $error("frame counter moved by other than one step or saturation");

  a_sw_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q.sw_left != '0 && held_q.sw_right != '0)
    else $error("held switch position is zero");

endmodule
